// File: hw/rtl/nhcs_pkg.sv
`timescale 1ns / 1ps
package nhcs_pkg;

	localparam int F_W             = 32;
	localparam int MOD_W           = 32;
	localparam int STRESS_W        = 48;
	localparam int CFG_IDX_W       = 2;
	localparam int F_FRAC_BITS_DEF = 28;
	localparam int N_COMP          = 6;
	localparam int N_NORMAL        = 3;

	// log2 mantissa fraction bits, one squaring stage per bit
	localparam int LOG_FRAC_W = 30;
	// ln 2 as Q0.30
	localparam int LN2_Q30    = 744261118;

	// products, minors and det, lead-one search and shift
	localparam int FRONT_STAGES = 8;
	// ln J scaling, moduli products, numerator, magnitude, divider set-up
	localparam int MID_STAGES   = 7;
	localparam int PIPE_DEPTH   = FRONT_STAGES + LOG_FRAC_W + MID_STAGES + STRESS_W + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LAMBDA = 2'd0,
		REG_SHEAR  = 2'd1
	} cfg_reg_t;

endpackage

// File: hw/rtl/neo_hookean_cauchy_stress.sv
`timescale 1ns / 1ps
// channel   | handshake               | payload
// ----------+-------------------------+-----------------------------------------
// item in   | start, busy             | f_xx f_xy f_xz f_yx f_yy f_yz f_zx f_zy f_zz
// result    | done (one-cycle strobe) | stress_xx .. stress_xy, bad_volume
// config    | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
// one item per cycle; each result is registered at the end of the pipeline
// the depth is dominated by the 30 log2 squaring stages and the 48 divider stages
// busy and cfg_ready are constant, the pipeline never holds
// arst_n clears the valid bits and the moduli; payload registers are not reset
module neo_hookean_cauchy_stress #(
	parameter int F_FRAC_BITS = nhcs_pkg::F_FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [nhcs_pkg::F_W-1:0]      f_xx,
	input  logic signed [nhcs_pkg::F_W-1:0]      f_xy,
	input  logic signed [nhcs_pkg::F_W-1:0]      f_xz,
	input  logic signed [nhcs_pkg::F_W-1:0]      f_yx,
	input  logic signed [nhcs_pkg::F_W-1:0]      f_yy,
	input  logic signed [nhcs_pkg::F_W-1:0]      f_yz,
	input  logic signed [nhcs_pkg::F_W-1:0]      f_zx,
	input  logic signed [nhcs_pkg::F_W-1:0]      f_zy,
	input  logic signed [nhcs_pkg::F_W-1:0]      f_zz,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [nhcs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nhcs_pkg::MOD_W-1:0]           cfg_data,
	output logic                                 done,
	output logic signed [nhcs_pkg::STRESS_W-1:0] stress_xx,
	output logic signed [nhcs_pkg::STRESS_W-1:0] stress_yy,
	output logic signed [nhcs_pkg::STRESS_W-1:0] stress_zz,
	output logic signed [nhcs_pkg::STRESS_W-1:0] stress_yz,
	output logic signed [nhcs_pkg::STRESS_W-1:0] stress_xz,
	output logic signed [nhcs_pkg::STRESS_W-1:0] stress_xy,
	output logic                                 bad_volume
);
	import nhcs_pkg::*;

	localparam int PROD_W   = 2 * F_W;
	localparam int MINOR_W  = PROD_W + 1;
	localparam int BSUM_W   = PROD_W + 2;
	localparam int BQ_W     = BSUM_W - F_FRAC_BITS;
	localparam int TP_W     = F_W + F_W + 1;
	localparam int TERM_W   = F_W + MINOR_W;
	localparam int JX_W     = TERM_W + 1;
	localparam int DEN_W    = JX_W - 2 * F_FRAC_BITS;
	localparam int CHUNK_W  = 8;
	localparam int CB_W     = $clog2(CHUNK_W);
	localparam int NCHUNK   = (JX_W + CHUNK_W - 1) / CHUNK_W;
	localparam int JXP_W    = NCHUNK * CHUNK_W;
	localparam int CI_W     = $clog2(NCHUNK);
	localparam int P_W      = CI_W + CB_W;
	localparam int MANT_W   = LOG_FRAC_W + 1;
	localparam int SHF_W    = JX_W + LOG_FRAC_W;
	localparam int LGI_W    = P_W + 1;
	localparam int LG_W     = LGI_W + LOG_FRAC_W;
	localparam int LG_LO_W  = LG_W / 2;
	localparam int LN2_W    = LOG_FRAC_W + 1;
	localparam int LNP_W    = LG_W + LN2_W;
	localparam int LNJ_W    = LNP_W - LOG_FRAC_W;
	localparam int LNJ_LO_W = LNJ_W / 2;
	localparam int MODS_W   = MOD_W + 1;
	localparam int CP_W     = MODS_W + LNJ_W;
	localparam int BQ_LO_W  = BQ_W / 2;
	localparam int MB_W     = MODS_W + BQ_W;
	localparam int NUM_W    = ((MB_W > CP_W) ? MB_W : CP_W) + 2;
	localparam int DIV_W    = ((NUM_W > DEN_W + STRESS_W) ? NUM_W : DEN_W + STRESS_W) + 1;
	localparam int CSH      = LOG_FRAC_W - F_FRAC_BITS;

	localparam int VI [N_COMP] = '{0, 1, 2, 1, 0, 0};
	localparam int VJ [N_COMP] = '{0, 1, 2, 2, 2, 1};
	localparam int MCA [3]     = '{1, 0, 0};
	localparam int MCB [3]     = '{2, 2, 1};

	localparam logic [STRESS_W-1:0] SAT_NEG = {1'b1, {(STRESS_W-1){1'b0}}};
	localparam logic [STRESS_W-1:0] SAT_POS = {1'b0, {(STRESS_W-1){1'b1}}};

	typedef struct packed {
		logic                           bad;
		logic [DEN_W-1:0]               jq;
		logic [N_COMP-1:0][BQ_W-1:0]    bq;
	} side_t;

	typedef struct packed {
		logic                bad;
		logic [DEN_W-1:0]    jq;
		logic [N_COMP-1:0]   neg;
		logic [N_COMP-1:0]   zero;
		logic [N_COMP-1:0]   sat;
	} dflag_t;

	logic [MOD_W-1:0]      lam_q;
	logic [MOD_W-1:0]      mu_q;
	logic [PIPE_DEPTH-1:0] vld_q;

	logic signed [F_W-1:0] fin [3][3];

	assign fin[0][0] = f_xx;
	assign fin[0][1] = f_xy;
	assign fin[0][2] = f_xz;
	assign fin[1][0] = f_yx;
	assign fin[1][1] = f_yy;
	assign fin[1][2] = f_yz;
	assign fin[2][0] = f_zx;
	assign fin[2][1] = f_zy;
	assign fin[2][2] = f_zz;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// control and moduli
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lam_q <= '0;
			mu_q  <= '0;
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], start && !busy};
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_LAMBDA: lam_q <= cfg_data;
					REG_SHEAR:  mu_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// stage 1: all 32x32 products
	logic signed [F_W-1:0]    f0_s1 [3];
	logic signed [PROD_W-1:0] pa_s1 [3];
	logic signed [PROD_W-1:0] pb_s1 [3];
	logic signed [PROD_W-1:0] bp_s1 [N_COMP][3];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			f0_s1[k] <= fin[0][k];
			pa_s1[k] <= fin[1][MCA[k]] * fin[2][MCB[k]];
			pb_s1[k] <= fin[1][MCB[k]] * fin[2][MCA[k]];
		end
		for (int k = 0; k < N_COMP; k++) begin
			for (int j = 0; j < 3; j++) begin
				bp_s1[k][j] <= fin[VI[k]][j] * fin[VJ[k]][j];
			end
		end
	end

	// stage 2: cofactors and B
	logic signed [F_W-1:0]     f0_s2 [3];
	logic signed [MINOR_W-1:0] minor_s2 [3];
	side_t                     sd_s2;
	logic signed [BSUM_W-1:0]  bsum [N_COMP];

	always_comb begin
		for (int k = 0; k < N_COMP; k++) begin
			bsum[k] = BSUM_W'(bp_s1[k][0]) + BSUM_W'(bp_s1[k][1]) + BSUM_W'(bp_s1[k][2]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			f0_s2[k]    <= f0_s1[k];
			minor_s2[k] <= MINOR_W'(pa_s1[k]) - MINOR_W'(pb_s1[k]);
		end
		sd_s2.bad <= 1'b0;
		sd_s2.jq  <= '0;
		for (int k = 0; k < N_COMP; k++) begin
			sd_s2.bq[k] <= bsum[k][BSUM_W-1:F_FRAC_BITS];
		end
	end

	// stage 3: det partial products, cofactor split in two halves
	logic signed [TP_W-1:0] tlo_s3 [3];
	logic signed [TP_W-1:0] thi_s3 [3];
	side_t                  sd_s3;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			tlo_s3[k] <= f0_s2[k] * $signed({1'b0, minor_s2[k][F_W-1:0]});
			thi_s3[k] <= f0_s2[k] * $signed(minor_s2[k][MINOR_W-1:F_W]);
		end
		sd_s3 <= sd_s2;
	end

	// stage 4 and 5: det terms, then det
	logic signed [TERM_W-1:0] term_s4 [3];
	side_t                    sd_s4;
	logic signed [JX_W-1:0]   jx_s5;
	side_t                    sd_s5;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			term_s4[k] <= (TERM_W'(thi_s3[k]) <<< F_W) + TERM_W'(tlo_s3[k]);
		end
		sd_s4 <= sd_s3;
		jx_s5 <= JX_W'(term_s4[0]) - JX_W'(term_s4[1]) + JX_W'(term_s4[2]);
		sd_s5 <= sd_s4;
	end

	// stage 6: lead-one search per byte
	logic [JX_W-1:0]   jx_u;
	logic [JXP_W-1:0]  jxp;
	logic [NCHUNK-1:0] cnz;
	logic [CB_W-1:0]   cpos [NCHUNK];

	assign jx_u = jx_s5;
	assign jxp  = JXP_W'(jx_u);

	always_comb begin
		for (int c = 0; c < NCHUNK; c++) begin
			cnz[c]  = |jxp[c*CHUNK_W +: CHUNK_W];
			cpos[c] = '0;
			for (int b = 0; b < CHUNK_W; b++) begin
				if (jxp[c*CHUNK_W + b]) begin
					cpos[c] = CB_W'(b);
				end
			end
		end
	end

	logic [JX_W-1:0]   jx_s6;
	logic [NCHUNK-1:0] cnz_s6;
	logic [CB_W-1:0]   cpos_s6 [NCHUNK];
	side_t             sd_s6;

	always_ff @(posedge clk) begin
		jx_s6    <= jx_u;
		cnz_s6   <= cnz;
		cpos_s6  <= cpos;
		sd_s6.jq <= sd_s5.jq;
		sd_s6.bq <= sd_s5.bq;
		// non-positive volume
		sd_s6.bad <= jx_s5[JX_W-1] || (jx_s5 == '0);
	end

	// stage 7: pick the top nonzero byte
	logic [P_W-1:0] ptop;

	always_comb begin
		ptop = '0;
		for (int c = 0; c < NCHUNK; c++) begin
			if (cnz_s6[c]) begin
				ptop = {CI_W'(c), cpos_s6[c]};
			end
		end
	end

	logic [JX_W-1:0] jx_s7;
	logic [P_W-1:0]  p_s7;
	side_t           sd_s7;

	always_ff @(posedge clk) begin
		jx_s7 <= jx_s6;
		p_s7  <= ptop;
		sd_s7 <= sd_s6;
	end

	// stage 8: normalize to a Q1.30 mantissa, then the squaring chain
	logic [MANT_W-1:0]     log_m_s    [LOG_FRAC_W+1];
	logic [LOG_FRAC_W-1:0] log_frac_s [LOG_FRAC_W+1];
	logic [P_W-1:0]        log_p_s    [LOG_FRAC_W+1];
	side_t                 log_sd_s   [LOG_FRAC_W+1];
	logic [SHF_W-1:0]      shv;

	assign shv = {jx_s7, {LOG_FRAC_W{1'b0}}} >> p_s7;

	always_ff @(posedge clk) begin
		log_m_s[0]       <= shv[MANT_W-1:0];
		log_frac_s[0]    <= '0;
		log_p_s[0]       <= p_s7;
		log_sd_s[0].bad  <= sd_s7.bad;
		log_sd_s[0].bq   <= sd_s7.bq;
		log_sd_s[0].jq   <= jx_s7[JX_W-1:2*F_FRAC_BITS];
	end

	for (genvar g = 0; g < LOG_FRAC_W; g++) begin : g_log
		logic [2*MANT_W-1:0] sq;
		logic [MANT_W:0]     sqh;

		assign sq  = log_m_s[g] * log_m_s[g];
		assign sqh = sq[2*MANT_W-1:LOG_FRAC_W];

		always_ff @(posedge clk) begin
			log_m_s[g+1]    <= sqh[MANT_W] ? sqh[MANT_W:1] : sqh[MANT_W-1:0];
			log_frac_s[g+1] <= log_frac_s[g] |
				(LOG_FRAC_W'(sqh[MANT_W]) << (LOG_FRAC_W - 1 - g));
			log_p_s[g+1]    <= log_p_s[g];
			log_sd_s[g+1]   <= log_sd_s[g];
		end
	end

	// stage 39: log2 J times ln 2, in two partial products
	logic signed [LGI_W-1:0] pint;
	logic [LG_W-1:0]         lg;
	logic signed [LN2_W-1:0] ln2_c;

	assign pint  = $signed({1'b0, log_p_s[LOG_FRAC_W]}) - $signed(LGI_W'(3 * F_FRAC_BITS));
	assign lg    = {pint, log_frac_s[LOG_FRAC_W]};
	assign ln2_c = $signed(LN2_W'(LN2_Q30));

	logic signed [LNP_W-1:0] lgh_s39;
	logic signed [LNP_W-1:0] lgl_s39;
	side_t                   sd_s39;

	always_ff @(posedge clk) begin
		lgh_s39 <= $signed(lg[LG_W-1:LG_LO_W]) * ln2_c;
		lgl_s39 <= $signed({1'b0, lg[LG_LO_W-1:0]}) * ln2_c;
		sd_s39  <= log_sd_s[LOG_FRAC_W];
	end

	// stage 40: ln J
	logic signed [LNP_W-1:0] lnp;
	logic signed [LNJ_W-1:0] lnj_s40;
	side_t                   sd_s40;

	assign lnp = (lgh_s39 <<< LG_LO_W) + lgl_s39;

	always_ff @(posedge clk) begin
		lnj_s40 <= lnp[LNP_W-1:LOG_FRAC_W];
		sd_s40  <= sd_s39;
	end

	// stage 41: lambda*lnJ and mu*B, each in two partial products
	logic signed [MODS_W-1:0] lam_s;
	logic signed [MODS_W-1:0] mu_s;

	assign lam_s = $signed({1'b0, lam_q});
	assign mu_s  = $signed({1'b0, mu_q});

	logic signed [CP_W-1:0] clo_s41;
	logic signed [CP_W-1:0] chi_s41;
	logic signed [MB_W-1:0] mbl_s41 [N_COMP];
	logic signed [MB_W-1:0] mbh_s41 [N_COMP];
	side_t                  sd_s41;

	always_ff @(posedge clk) begin
		clo_s41 <= lam_s * $signed({1'b0, lnj_s40[LNJ_LO_W-1:0]});
		chi_s41 <= lam_s * $signed(lnj_s40[LNJ_W-1:LNJ_LO_W]);
		for (int k = 0; k < N_COMP; k++) begin
			mbl_s41[k] <= mu_s * $signed({1'b0, sd_s40.bq[k][BQ_LO_W-1:0]});
			mbh_s41[k] <= mu_s * $signed(sd_s40.bq[k][BQ_W-1:BQ_LO_W]);
		end
		sd_s41 <= sd_s40;
	end

	// stage 42: diagonal term and mu*B
	logic signed [CP_W-1:0]  lamlnj;
	logic signed [NUM_W-1:0] cdiag;

	assign lamlnj = (chi_s41 <<< LNJ_LO_W) + clo_s41;
	assign cdiag  = NUM_W'(lamlnj >>> CSH) - (NUM_W'(mu_s) <<< F_FRAC_BITS);

	logic signed [NUM_W-1:0] c_s42;
	logic signed [NUM_W-1:0] mb_s42 [N_COMP];
	side_t                   sd_s42;

	always_ff @(posedge clk) begin
		c_s42 <= cdiag;
		for (int k = 0; k < N_COMP; k++) begin
			mb_s42[k] <= (NUM_W'(mbh_s41[k]) <<< BQ_LO_W) + NUM_W'(mbl_s41[k]);
		end
		sd_s42 <= sd_s41;
	end

	// stage 43: numerators
	logic signed [NUM_W-1:0] num_s43 [N_COMP];
	side_t                   sd_s43;

	always_ff @(posedge clk) begin
		for (int k = 0; k < N_COMP; k++) begin
			num_s43[k] <= mb_s42[k] + ((k < N_NORMAL) ? c_s42 : '0);
		end
		sd_s43 <= sd_s42;
	end

	// stage 44: sign and magnitude
	logic [NUM_W-1:0]  mag_s44 [N_COMP];
	logic [N_COMP-1:0] neg_s44;
	logic [N_COMP-1:0] zero_s44;
	side_t             sd_s44;

	always_ff @(posedge clk) begin
		for (int k = 0; k < N_COMP; k++) begin
			neg_s44[k]  <= num_s43[k][NUM_W-1];
			zero_s44[k] <= (num_s43[k] == '0);
			mag_s44[k]  <= num_s43[k][NUM_W-1] ? NUM_W'(-num_s43[k]) : NUM_W'(num_s43[k]);
		end
		sd_s44 <= sd_s43;
	end

	// stage 45: overflow test, then one quotient bit per stage
	logic [DIV_W-1:0]    div_rem_s [STRESS_W+1][N_COMP];
	logic [STRESS_W-1:0] div_q_s   [STRESS_W+1][N_COMP];
	dflag_t              div_fl_s  [STRESS_W+1];
	logic [DIV_W-1:0]    den_top;

	// a quotient of 2^48 or more, or a zero divisor, saturates
	assign den_top = DIV_W'(sd_s44.jq) << STRESS_W;

	always_ff @(posedge clk) begin
		for (int k = 0; k < N_COMP; k++) begin
			div_rem_s[0][k]    <= DIV_W'(mag_s44[k]);
			div_q_s[0][k]      <= '0;
			div_fl_s[0].sat[k] <= DIV_W'(mag_s44[k]) >= den_top;
		end
		div_fl_s[0].bad  <= sd_s44.bad;
		div_fl_s[0].jq   <= sd_s44.jq;
		div_fl_s[0].neg  <= neg_s44;
		div_fl_s[0].zero <= zero_s44;
	end

	for (genvar g = 0; g < STRESS_W; g++) begin : g_div
		logic [DIV_W-1:0] dsh;

		assign dsh = DIV_W'(div_fl_s[g].jq) << (STRESS_W - 1 - g);

		always_ff @(posedge clk) begin
			div_fl_s[g+1] <= div_fl_s[g];
			for (int k = 0; k < N_COMP; k++) begin
				if (div_rem_s[g][k] >= dsh) begin
					div_rem_s[g+1][k] <= div_rem_s[g][k] - dsh;
					div_q_s[g+1][k]   <= div_q_s[g][k] |
						(STRESS_W'(1) << (STRESS_W - 1 - g));
				end else begin
					div_rem_s[g+1][k] <= div_rem_s[g][k];
					div_q_s[g+1][k]   <= div_q_s[g][k];
				end
			end
		end
	end

	// output stage: clamp and sign
	logic [STRESS_W-1:0] res [N_COMP];
	logic [STRESS_W-1:0] qv  [N_COMP];
	logic [N_COMP-1:0]   over;
	dflag_t              flo;

	assign flo = div_fl_s[STRESS_W];

	always_comb begin
		for (int k = 0; k < N_COMP; k++) begin
			qv[k]   = div_q_s[STRESS_W][k];
			over[k] = flo.neg[k] ? (qv[k] > SAT_NEG) : qv[k][STRESS_W-1];
			if (flo.bad || flo.zero[k]) begin
				res[k] = '0;
			end else if (flo.sat[k] || over[k]) begin
				res[k] = flo.neg[k] ? SAT_NEG : SAT_POS;
			end else begin
				res[k] = flo.neg[k] ? STRESS_W'(-qv[k]) : qv[k];
			end
		end
	end

	logic [STRESS_W-1:0] stress_q [N_COMP];
	logic                bad_q;

	always_ff @(posedge clk) begin
		stress_q <= res;
		bad_q    <= flo.bad;
	end

	assign done       = vld_q[PIPE_DEPTH-1];
	assign stress_xx  = $signed(stress_q[0]);
	assign stress_yy  = $signed(stress_q[1]);
	assign stress_zz  = $signed(stress_q[2]);
	assign stress_yz  = $signed(stress_q[3]);
	assign stress_xz  = $signed(stress_q[4]);
	assign stress_xy  = $signed(stress_q[5]);
	assign bad_volume = bad_q;

endmodule

// File: hw/rtl/nhcs_chk.sv
`timescale 1ns / 1ps
module nhcs_chk (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic                                 cfg_valid,
	input logic                                 cfg_ready,
	input logic                                 done,
	input logic signed [nhcs_pkg::STRESS_W-1:0] stress_xx,
	input logic signed [nhcs_pkg::STRESS_W-1:0] stress_yy,
	input logic signed [nhcs_pkg::STRESS_W-1:0] stress_zz,
	input logic signed [nhcs_pkg::STRESS_W-1:0] stress_yz,
	input logic signed [nhcs_pkg::STRESS_W-1:0] stress_xz,
	input logic signed [nhcs_pkg::STRESS_W-1:0] stress_xy,
	input logic                                 bad_volume
);
	import nhcs_pkg::*;

	// a collapsed element gives an all-zero stress
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && bad_volume |-> (stress_xx == '0 && stress_yy == '0 && stress_zz == '0 &&
			stress_yz == '0 && stress_xz == '0 && stress_xy == '0))
		else $error("bad volume item with nonzero stress");

	// every result traces back to an item taken a fixed depth earlier
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_DEPTH))
		else $error("result without matching item");

	// the pipeline and the config port never hold off
	a_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && (!cfg_valid || cfg_ready))
		else $error("block held off an item or a config write");

endmodule

bind neo_hookean_cauchy_stress nhcs_chk u_nhcs_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.cfg_valid  (cfg_valid),
	.cfg_ready  (cfg_ready),
	.done       (done),
	.stress_xx  (stress_xx),
	.stress_yy  (stress_yy),
	.stress_zz  (stress_zz),
	.stress_yz  (stress_yz),
	.stress_xz  (stress_xz),
	.stress_xy  (stress_xy),
	.bad_volume (bad_volume)
);

// File: dv/neo_hookean_cauchy_stress_tb.sv
`timescale 1ns / 1ps
module neo_hookean_cauchy_stress_tb;
	import nhcs_pkg::*;

	localparam int FB = F_FRAC_BITS_DEF;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
	localparam logic [31:0] ONE_F = 32'h1000_0000;

	typedef logic [8:0][31:0] fmat_t;
	typedef struct packed {
		logic [5:0][STRESS_W-1:0] s;
		logic                     bad;
	} stress_t;

	logic clk, arst_n, start, busy, cfg_valid, cfg_ready, done, bad_volume;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [MOD_W-1:0] cfg_data;
	logic signed [F_W-1:0] f_xx, f_xy, f_xz, f_yx, f_yy, f_yz, f_zx, f_zy, f_zz;
	logic signed [STRESS_W-1:0] stress_xx, stress_yy, stress_zz, stress_yz, stress_xz, stress_xy;

	fmat_t pending_f[$];
	stress_t stress_expected[$];
	fmat_t driven_f;
	logic [31:0] lam_q, mu_q;
	int idle_pct;
	int mismatches;

	neo_hookean_cauchy_stress dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.f_xx(f_xx), .f_xy(f_xy), .f_xz(f_xz), .f_yx(f_yx), .f_yy(f_yy),
		.f_yz(f_yz), .f_zx(f_zx), .f_zy(f_zy), .f_zz(f_zz),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done),
		.stress_xx(stress_xx), .stress_yy(stress_yy), .stress_zz(stress_zz),
		.stress_yz(stress_yz), .stress_xz(stress_xz), .stress_xy(stress_xy),
		.bad_volume(bad_volume)
	);

	function automatic logic signed [127:0] wmul(longint a, longint b);
		logic signed [127:0] x, y;
		x = a;
		y = b;
		return x * y;
	endfunction

	function automatic logic [STRESS_W-1:0] sat_div(logic signed [127:0] num,
			logic signed [127:0] jq);
		logic neg;
		logic [127:0] mag, q, lim;
		neg = num[127];
		mag = neg ? -num : num;
		lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
		if (mag == 0)
			return '0;
		if (jq == 0)
			q = lim;
		else begin
			q = mag / jq;
			if (q > lim)
				q = lim;
		end
		q = neg ? -q : q;
		return q[STRESS_W-1:0];
	endfunction

	function automatic stress_t cauchy_stress(fmat_t fm, logic [31:0] lam_r, logic [31:0] mu_r);
		longint f[9];
		longint bq[9];
		longint mn0, mn1, mn2, lg, lnj, lam, mu;
		logic signed [127:0] jx, jq, s, cterm, num;
		logic [63:0] m, frac;
		int p;
		int ix[6];
		stress_t r;
		ix = '{0, 4, 8, 5, 2, 1};
		r = '0;
		for (int i = 0; i < 9; i++)
			f[i] = $signed(fm[i]);
		lam = longint'({32'd0, lam_r});
		mu = longint'({32'd0, mu_r});
		// 2x2 minors wrap at 64 bits
		mn0 = f[4] * f[8] - f[5] * f[7];
		mn1 = f[3] * f[8] - f[5] * f[6];
		mn2 = f[3] * f[7] - f[4] * f[6];
		jx = wmul(f[0], mn0) - wmul(f[1], mn1) + wmul(f[2], mn2);
		if (jx <= 0) begin
			r.bad = 1'b1;
			return r;
		end
		for (int a = 0; a < 3; a++)
			for (int b = 0; b < 3; b++) begin
				s = wmul(f[3*a], f[3*b]) + wmul(f[3*a+1], f[3*b+1]) + wmul(f[3*a+2], f[3*b+2]);
				bq[3*a+b] = longint'(s >>> FB);
			end
		p = 0;
		for (int i = 0; i < 128; i++)
			if (jx[i])
				p = i;
		if (p >= 30)
			m = 64'(jx >>> (p - 30));
		else
			m = 64'(jx) << (30 - p);
		frac = '0;
		for (int k = 29; k >= 0; k--) begin
			m = (m * m) >> 30;
			if (m >= 64'h8000_0000) begin
				frac[k] = 1'b1;
				m = m >> 1;
			end
		end
		lg = (longint'(p) - 3 * FB) * 64'sd1073741824 + longint'(frac);
		lnj = longint'(wmul(lg, LN2_Q30) >>> 30);
		cterm = (wmul(lam, lnj) >>> (30 - FB)) - wmul(mu, longint'(1) << FB);
		jq = jx >>> (2 * FB);
		for (int k = 0; k < N_COMP; k++) begin
			num = wmul(mu, bq[ix[k]]);
			if (k < N_NORMAL)
				num = num + cterm;
			r.s[k] = sat_div(num, jq);
		end
		return r;
	endfunction

	function automatic fmat_t diag_f(logic [31:0] a, logic [31:0] b, logic [31:0] c);
		fmat_t x;
		x = '0;
		x[0] = a;
		x[4] = b;
		x[8] = c;
		return x;
	endfunction

	function automatic fmat_t random_f();
		fmat_t x;
		int sel, sh;
		sel = $urandom_range(99);
		sh = $urandom_range(14);
		for (int i = 0; i < 9; i++) begin
			if (sel < 60)
				x[i] = ((i % 4 == 0) ? ONE_F : 32'd0)
					+ (($signed($urandom) >>> (4 + sh)));
			else if (sel < 78)
				x[i] = $urandom;
			else if (sel < 86)
				x[i] = (i % 4 == 0) ? $urandom_range(40000) : ($signed($urandom) >>> 20);
			else
				x[i] = ((i % 4 == 0) ? ONE_F : 32'd0) + ($signed($urandom) >>> (5 + sh));
		end
		// flip one row for inverted volume
		if (sel >= 86 && sel < 96) begin
			sh = $urandom_range(2);
			for (int k = 0; k < 3; k++)
				x[3*sh+k] = -x[3*sh+k];
		end
		if (sel >= 96)
			x[$urandom_range(8)] = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
		return x;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_LAMBDA)
			lam_q = val;
		else if (idx == REG_SHEAR)
			mu_q = val;
		cfg_valid <= 1'b0;
	endtask

	// checked between edges so the driver's updates have settled
	task automatic drain();
		do @(negedge clk); while (pending_f.size() != 0 || stress_expected.size() != 0 || start);
	endtask

	task automatic run_phase(logic [31:0] lam, logic [31:0] mu, int n, int idle);
		write_reg(REG_LAMBDA, lam);
		write_reg(REG_SHEAR, mu);
		idle_pct = idle;
		for (int i = 0; i < n; i++)
			pending_f.push_back(random_f());
		drain();
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				stress_expected.push_back(cauchy_stress(driven_f, lam_q, mu_q));
			if ((!start || !busy) && pending_f.size() != 0 && $urandom_range(99) >= idle_pct)
				begin
				driven_f = pending_f.pop_front();
				start <= 1'b1;
				{f_zz, f_zy, f_zx, f_yz, f_yy, f_yx, f_xz, f_xy, f_xx} <= driven_f;
			end else if (!start || !busy) begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		stress_t got, want;
		if (arst_n && done) begin
			got.s = {stress_xy, stress_xz, stress_yz, stress_zz, stress_yy, stress_xx};
			got.bad = bad_volume;
			if (stress_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
			end else begin
				want = stress_expected.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h actual %h", want, got);
				end
			end
		end
	end

	initial begin
		mismatches = 0;
		idle_pct = 0;
		lam_q = '0;
		mu_q = '0;
		driven_f = '0;
		arst_n = 1'b0;
		start = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		{f_zz, f_zy, f_zx, f_yz, f_yy, f_yx, f_xz, f_xy, f_xx} = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset moduli first
		pending_f.push_back(diag_f(ONE_F, ONE_F, ONE_F));
		drain();

		write_reg(REG_LAMBDA, 32'h0002_0000);
		write_reg(REG_SHEAR, 32'h0001_0000);
		// writes to unused indexes must leave the moduli alone
		write_reg(REG_SPARE_LO, 32'hffff_ffff);
		write_reg(REG_SPARE_HI, 32'h1234_5678);
		pending_f.push_back(diag_f(ONE_F, ONE_F, ONE_F));
		pending_f.push_back(diag_f(ONE_F << 1, ONE_F << 1, ONE_F << 1));
		pending_f.push_back(diag_f(ONE_F >> 1, ONE_F >> 1, ONE_F >> 1));
		pending_f.push_back(diag_f(ONE_F, ONE_F >> 3, ONE_F << 2));
		pending_f.push_back('0);
		pending_f.push_back(diag_f(-ONE_F, ONE_F, ONE_F));
		pending_f.push_back(diag_f(32'd1, 32'd1, 32'd1));
		pending_f.push_back(diag_f(32'd1000, 32'd1000, 32'd1000));
		pending_f.push_back(diag_f(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
		pending_f.push_back(diag_f(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		pending_f.push_back(diag_f(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
		pending_f.push_back({9{32'h7fff_ffff}});
		pending_f.push_back({9{32'h8000_0000}});
		pending_f.push_back({9{32'hffff_ffff}});
		pending_f.push_back({32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
		begin
			fmat_t sh;
			sh = diag_f(ONE_F, ONE_F, ONE_F);
			sh[1] = ONE_F >> 1;
			sh[5] = -(ONE_F >> 2);
			sh[6] = ONE_F >> 3;
			pending_f.push_back(sh);
		end
		for (int i = 0; i < 6; i++)
			pending_f.push_back(random_f());
		drain();

		write_reg(REG_LAMBDA, 32'hffff_ffff);
		write_reg(REG_SHEAR, 32'hffff_ffff);
		for (int i = 0; i < 6; i++)
			pending_f.push_back(diag_f(32'd1 << (4 * i), ONE_F, ONE_F << 1));
		drain();

		run_phase(32'h0002_0000, 32'h0001_0000, 300, 0);
		run_phase(32'hffff_ffff, 32'hffff_ffff, 280, 62);
		run_phase(32'd0, 32'd0, 200, 0);
		run_phase($urandom, $urandom, 280, 10);
		run_phase($urandom_range(32'h00ff_ffff), $urandom_range(32'h00ff_ffff), 300, 62);
		run_phase(32'd0, 32'hffff_ffff, 150, 10);
		run_phase(32'hffff_ffff, 32'd1, 150, 0);

		repeat (150) @(posedge clk);
		if (mismatches == 0 && stress_expected.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
